FILE: design/sqt_pkg.sv
package sqt_pkg;

	localparam int DEF_LINE_WIDTH   = 16;
	localparam int DEF_COLUMN_WIDTH = 16;
	localparam int DEF_LENGTH_WIDTH = 16;
	localparam int DEF_MID_DEPTH    = 2;
	localparam int DEF_OUT_DEPTH    = 4;

	// scan modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_WORD   = 2'd1;
	localparam logic [1:0] MODE_NUMBER = 2'd2;
	localparam logic [1:0] MODE_STRING = 2'd3;

	// token types
	localparam logic [4:0] TT_IDENT   = 5'd0;
	localparam logic [4:0] TT_INT     = 5'd10;
	localparam logic [4:0] TT_FLOAT   = 5'd11;
	localparam logic [4:0] TT_STRING  = 5'd12;
	localparam logic [4:0] TT_LPAREN  = 5'd13;
	localparam logic [4:0] TT_RPAREN  = 5'd14;
	localparam logic [4:0] TT_COMMA   = 5'd15;
	localparam logic [4:0] TT_SEMI    = 5'd16;
	localparam logic [4:0] TT_UNKNOWN = 5'd17;
	localparam logic [4:0] TT_END     = 5'd18;

	// byte classes
	localparam logic [2:0] CL_SPACE   = 3'd0;
	localparam logic [2:0] CL_NEWLINE = 3'd1;
	localparam logic [2:0] CL_WORD    = 3'd2;
	localparam logic [2:0] CL_DIGIT   = 3'd3;
	localparam logic [2:0] CL_DOT     = 3'd4;
	localparam logic [2:0] CL_SQUOTE  = 3'd5;
	localparam logic [2:0] CL_DQUOTE  = 3'd6;
	localparam logic [2:0] CL_SYMBOL  = 3'd7;

	localparam int NUM_KW     = 9;
	localparam int PREFIX_LEN = 6;

	// keywords packed first byte most significant, right aligned
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h4352_4541_5445, // CREATE
		48'h0054_4142_4C45, // TABLE
		48'h494E_5345_5254, // INSERT
		48'h0000_494E_544F, // INTO
		48'h5641_4C55_4553, // VALUES
		48'h5345_4C45_4354, // SELECT
		48'h0000_4652_4F4D, // FROM
		48'h4445_4C45_5445, // DELETE
		48'h0057_4845_5245  // WHERE
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd6, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd4, 3'd6, 3'd5
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] text_byte;
	} item_t;

	typedef struct packed {
		logic [4:0]  token_type;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [15:0] token_length;
		logic [7:0]  symbol_byte;
		logic        last_of_run;
	} token_t;

	typedef struct packed {
		logic       is_end;
		logic [2:0] cls;
		logic [4:0] sym_type;
		logic [7:0] text_byte;
	} cls_item_t;

endpackage

FILE: design/sql_subset_tokenizer.sv
// Path: a byte goes through the mid queue and the back end; any token it yields is written
// into the result queue. Throughput: one byte per cycle while the result queue has room; a
// byte that closes a token and also yields a single-byte token, or an end mark that
// closes a token, holds the lexer while the second token waits in the pending slot.
// Reset: arst_n clears both queues and returns line, column and scan state to line 1,
// column 1, idle; no clearing pass is needed.
module sql_subset_tokenizer #(
	parameter int LINE_WIDTH   = sqt_pkg::DEF_LINE_WIDTH,
	parameter int COLUMN_WIDTH = sqt_pkg::DEF_COLUMN_WIDTH,
	parameter int LENGTH_WIDTH = sqt_pkg::DEF_LENGTH_WIDTH,
	parameter int MID_DEPTH    = sqt_pkg::DEF_MID_DEPTH,
	parameter int OUT_DEPTH    = sqt_pkg::DEF_OUT_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  sqt_pkg::item_t  item,
	output logic            empty,
	input  logic            pop,
	output sqt_pkg::token_t token
);
	import sqt_pkg::*;

	logic      mid_push, mid_full, mid_pop, mid_empty;
	cls_item_t mid_wdata, mid_rdata;
	logic      out_push, out_full;
	token_t    out_wdata;

	sqt_front u_front (
		.push     (push),
		.item     (item),
		.full     (full),
		.mid_push (mid_push),
		.mid_data (mid_wdata),
		.mid_full (mid_full)
	);

	sqt_fifo #(.T(cls_item_t), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	sqt_back #(
		.LINE_WIDTH  (LINE_WIDTH),
		.COLUMN_WIDTH(COLUMN_WIDTH),
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_data (mid_rdata),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.out_push (out_push),
		.out_data (out_wdata),
		.out_full (out_full)
	);

	sqt_fifo #(.T(token_t), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.full  (out_full),
		.pop   (pop),
		.rdata (token),
		.empty (empty)
	);
endmodule

FILE: design/sqt_fifo.sv
module sqt_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            wr, rd;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

FILE: design/sqt_front.sv
module sqt_front (
	input  logic              push,
	input  sqt_pkg::item_t    item,
	output logic              full,
	output logic              mid_push,
	output sqt_pkg::cls_item_t mid_data,
	input  logic              mid_full
);
	import sqt_pkg::*;

	logic [2:0] cls;
	logic [4:0] sym_type;

	always_comb begin
		sym_type = TT_UNKNOWN;
		unique case (item.text_byte) inside
			8'h0A:                         cls = CL_NEWLINE;
			8'h09, [8'h0B:8'h0D], 8'h20:   cls = CL_SPACE;
			[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: cls = CL_WORD;
			[8'h30:8'h39]:                 cls = CL_DIGIT;
			8'h2E:                         cls = CL_DOT;
			8'h27:                         cls = CL_SQUOTE;
			8'h22:                         cls = CL_DQUOTE;
			8'h28: begin
				cls      = CL_SYMBOL;
				sym_type = TT_LPAREN;
			end
			8'h29: begin
				cls      = CL_SYMBOL;
				sym_type = TT_RPAREN;
			end
			8'h2C: begin
				cls      = CL_SYMBOL;
				sym_type = TT_COMMA;
			end
			8'h3B: begin
				cls      = CL_SYMBOL;
				sym_type = TT_SEMI;
			end
			default:                       cls = CL_SYMBOL;
		endcase
	end

	assign full               = mid_full;
	assign mid_push           = push;
	assign mid_data.is_end    = item.kind;
	assign mid_data.cls       = cls;
	assign mid_data.sym_type  = sym_type;
	assign mid_data.text_byte = item.text_byte;
endmodule

FILE: design/sqt_back.sv
module sqt_back #(
	parameter int LINE_WIDTH   = sqt_pkg::DEF_LINE_WIDTH,
	parameter int COLUMN_WIDTH = sqt_pkg::DEF_COLUMN_WIDTH,
	parameter int LENGTH_WIDTH = sqt_pkg::DEF_LENGTH_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sqt_pkg::cls_item_t mid_data,
	input  logic               mid_empty,
	output logic               mid_pop,
	output logic               out_push,
	output sqt_pkg::token_t    out_data,
	input  logic               out_full
);
	import sqt_pkg::*;

	localparam int LW = LINE_WIDTH;
	localparam int CW = COLUMN_WIDTH;
	localparam int NW = LENGTH_WIDTH;

	logic [1:0]    mode_q, mode_n;
	logic          dbl_q, dbl_n;
	logic          dot_q, dot_n;
	logic [LW-1:0] line_q, line_n;
	logic [CW-1:0] col_q, col_n;
	logic [CW-1:0] start_q, start_n;
	logic [NW-1:0] run_q, run_n;
	logic [47:0]   prefix_q, prefix_n;
	logic          pend_valid_q;
	token_t        pend_q;

	logic [LW-1:0] line_inc;
	logic [CW-1:0] col_inc;
	logic [NW-1:0] run_inc;
	logic [4:0]    word_type;
	logic [4:0]    close_type;
	logic          go;
	logic          a_v, b_v;
	token_t        tok_a, tok_b;
	logic          quote_hit;

	function automatic token_t mk_token(input logic [4:0] ty, input logic [LW-1:0] ln,
			input logic [CW-1:0] c, input logic [NW-1:0] len, input logic [7:0] sym);
		logic [31:0] l32, c32, n32;
		token_t      t;
		l32            = 32'(ln);
		c32            = 32'(c);
		n32            = 32'(len);
		t.token_type   = ty;
		t.token_line   = l32[15:0];
		t.token_column = c32[15:0];
		t.token_length = n32[15:0];
		t.symbol_byte  = sym;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
	assign col_inc  = (col_q == '1) ? col_q : col_q + 1'b1;
	assign run_inc  = (run_q == '1) ? run_q : run_q + 1'b1;

	always_comb begin
		word_type = TT_IDENT;
		for (int k = 0; k < NUM_KW; k++) begin
			if (run_q == NW'(KW_LEN[k]) && prefix_q == KW_TEXT[k]) begin
				word_type = 5'(k + 1);
			end
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_WORD:   close_type = word_type;
			MODE_NUMBER: close_type = dot_q ? TT_FLOAT : TT_INT;
			MODE_STRING: close_type = TT_STRING;
			default:     close_type = TT_IDENT;
		endcase
	end

	assign quote_hit = dbl_q ? (mid_data.cls == CL_DQUOTE) : (mid_data.cls == CL_SQUOTE);
	assign go        = !mid_empty && !pend_valid_q && !out_full;
	assign mid_pop   = go;

	always_comb begin
		mode_n   = mode_q;
		dbl_n    = dbl_q;
		dot_n    = dot_q;
		line_n   = line_q;
		col_n    = col_q;
		start_n  = start_q;
		run_n    = run_q;
		prefix_n = prefix_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		tok_a    = mk_token(close_type, line_q, start_q, run_q, 8'h00);
		tok_b    = mk_token(mid_data.sym_type, line_q, col_q, NW'(1), mid_data.text_byte);
		if (mid_data.is_end) begin
			// close open token, then end mark; state returns to reset
			a_v      = (mode_q != MODE_IDLE);
			b_v      = 1'b1;
			tok_b    = mk_token(TT_END, line_q, col_q, '0, 8'h00);
			mode_n   = MODE_IDLE;
			dbl_n    = 1'b0;
			dot_n    = 1'b0;
			line_n   = LW'(1);
			col_n    = CW'(1);
			start_n  = CW'(1);
			run_n    = '0;
			prefix_n = '0;
		end else if (mode_q == MODE_STRING) begin
			if (quote_hit) begin
				a_v    = 1'b1;
				mode_n = MODE_IDLE;
			end else begin
				run_n = run_inc;
			end
			col_n = col_inc;
		end else if (mode_q == MODE_WORD &&
				(mid_data.cls == CL_WORD || mid_data.cls == CL_DIGIT)) begin
			if (run_q < NW'(PREFIX_LEN)) begin
				prefix_n = {prefix_q[39:0], mid_data.text_byte};
			end
			run_n = run_inc;
			col_n = col_inc;
		end else if (mode_q == MODE_NUMBER &&
				(mid_data.cls == CL_DIGIT || mid_data.cls == CL_DOT)) begin
			if (mid_data.cls == CL_DOT) begin
				dot_n = 1'b1;
			end
			run_n = run_inc;
			col_n = col_inc;
		end else begin
			a_v    = (mode_q != MODE_IDLE);
			mode_n = MODE_IDLE;
			case (mid_data.cls)
				CL_NEWLINE: begin
					line_n = line_inc;
					col_n  = CW'(1);
				end
				CL_SPACE: col_n = col_inc;
				CL_WORD: begin
					mode_n   = MODE_WORD;
					start_n  = col_q;
					col_n    = col_inc;
					run_n    = NW'(1);
					prefix_n = {40'h0, mid_data.text_byte};
				end
				CL_DIGIT: begin
					mode_n  = MODE_NUMBER;
					start_n = col_q;
					col_n   = col_inc;
					run_n   = NW'(1);
					dot_n   = 1'b0;
				end
				CL_SQUOTE, CL_DQUOTE: begin
					mode_n  = MODE_STRING;
					dbl_n   = (mid_data.cls == CL_DQUOTE);
					col_n   = col_inc;
					start_n = col_inc;
					run_n   = '0;
				end
				default: begin
					b_v   = 1'b1;
					col_n = col_inc;
				end
			endcase
		end
	end

	// first token goes out now, a second one waits in the pending slot until the result queue takes it
	always_comb begin
		out_push = 1'b0;
		out_data = tok_b;
		if (pend_valid_q) begin
			out_push = !out_full;
			out_data = pend_q;
		end else if (go && a_v) begin
			out_push             = 1'b1;
			out_data             = tok_a;
			out_data.last_of_run = !b_v;
		end else if (go && b_v) begin
			out_push             = 1'b1;
			out_data.last_of_run = 1'b1;
		end
	end

	// the held token is always the last of its transaction
	always_ff @(posedge clk) begin
		if (go && a_v && b_v) begin
			pend_q <= {tok_b[$bits(token_t)-1:1], 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			dbl_q        <= 1'b0;
			dot_q        <= 1'b0;
			line_q       <= LW'(1);
			col_q        <= CW'(1);
			start_q      <= CW'(1);
			run_q        <= '0;
			prefix_q     <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (go) begin
				mode_q   <= mode_n;
				dbl_q    <= dbl_n;
				dot_q    <= dot_n;
				line_q   <= line_n;
				col_q    <= col_n;
				start_q  <= start_n;
				run_q    <= run_n;
				prefix_q <= prefix_n;
			end
			if (pend_valid_q) begin
				pend_valid_q <= out_full;
			end else if (go && a_v && b_v) begin
				pend_valid_q <= 1'b1;
			end
		end
	end
endmodule

FILE: design/sqt_checker.sv
module sqt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            empty,
	input logic            pop,
	input sqt_pkg::token_t token
);
	import sqt_pkg::*;

	// a waiting transaction holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(token))
		else $error("result changed while stalled");

	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token.token_type == TT_END |->
			token.token_length == 16'd0 && token.last_of_run && token.symbol_byte == 8'h00)
		else $error("malformed end token");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token.token_type >= TT_LPAREN && token.token_type <= TT_UNKNOWN |->
			token.token_length == 16'd1 && token.last_of_run)
		else $error("single-byte token malformed");

	a_no_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token.token_type < TT_LPAREN |-> token.symbol_byte == 8'h00)
		else $error("symbol byte set on multi-byte token");

	a_type_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> token.token_type <= TT_END)
		else $error("token type out of range");
endmodule

bind sql_subset_tokenizer sqt_checker u_sqt_checker (.*);

FILE: bench/sqt_token_checker.sv
`timescale 1ns / 100ps
module sqt_token_checker
	import sqt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  logic   full,
	input  item_t  item,
	input  logic   empty,
	input  logic   pop,
	input  token_t token,
	output int     mismatches,
	output int     pending
);

	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [7:0]  CH_NEWLINE = 8'h0A;
	localparam logic [7:0]  CH_SQUOTE  = 8'h27;
	localparam logic [7:0]  CH_DQUOTE  = 8'h22;
	localparam logic [7:0]  CH_UNDER   = 8'h5F;
	localparam logic [7:0]  CH_DOT     = 8'h2E;

	// lexer state as the predictor sees it
	logic [1:0]  scan_state;
	logic        dquote_open;
	logic        dot_seen;
	logic [15:0] line_no;
	logic [15:0] col_no;
	logic [15:0] token_col;
	logic [15:0] run_len;
	logic [47:0] prefix;

	token_t step_tokens[$];
	token_t expected_tokens[$];
	int     checked;

	function automatic string keyword_text(int k);
		case (k)
			0:       return "CREATE";
			1:       return "TABLE";
			2:       return "INSERT";
			3:       return "INTO";
			4:       return "VALUES";
			5:       return "SELECT";
			6:       return "FROM";
			7:       return "DELETE";
			default: return "WHERE";
		endcase
	endfunction

	function automatic logic [15:0] bump(logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic logic is_letter(logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic void lexer_clear();
		scan_state  = MODE_IDLE;
		dquote_open = 1'b0;
		dot_seen    = 1'b0;
		line_no     = 16'd1;
		col_no      = 16'd1;
		token_col   = 16'd1;
		run_len     = 16'd0;
		prefix      = '0;
	endfunction

	function automatic void note_token(logic [4:0] ty, logic [15:0] col, logic [15:0] len,
			logic [7:0] sym);
		token_t t;
		t.token_type   = ty;
		t.token_line   = line_no;
		t.token_column = col;
		t.token_length = len;
		t.symbol_byte  = sym;
		t.last_of_run  = 1'b0;
		step_tokens    = {step_tokens, t};
	endfunction

	// only words of one to six characters can be keywords
	function automatic logic [4:0] word_kind();
		string       kw;
		logic [47:0] packed_kw;
		if (run_len < 1 || run_len > PREFIX_LEN)
			return TT_IDENT;
		for (int k = 0; k < NUM_KW; k++) begin
			kw = keyword_text(k);
			packed_kw = '0;
			for (int i = 0; i < kw.len(); i++)
				packed_kw = {packed_kw[39:0], kw[i]};
			if (kw.len() == run_len && packed_kw == prefix)
				return 5'(k + 1);
		end
		return TT_IDENT;
	endfunction

	function automatic void close_open();
		case (scan_state)
			MODE_WORD:   note_token(word_kind(), token_col, run_len, 8'd0);
			MODE_NUMBER: note_token(dot_seen ? TT_FLOAT : TT_INT, token_col, run_len, 8'd0);
			MODE_STRING: note_token(TT_STRING, token_col, run_len, 8'd0);
			default: ;
		endcase
		scan_state = MODE_IDLE;
	endfunction

	function automatic void lex_byte(item_t it);
		logic [7:0] b;
		logic [4:0] ty;
		token_t     t;
		b = it.text_byte;
		if (it.kind) begin
			// end of input: flush, mark the end, start a fresh text
			close_open();
			note_token(TT_END, col_no, 16'd0, 8'd0);
			lexer_clear();
		end else if (scan_state == MODE_STRING) begin
			if (b == (dquote_open ? CH_DQUOTE : CH_SQUOTE))
				close_open();
			else
				run_len = bump(run_len);
			col_no = bump(col_no);
		end else if (scan_state == MODE_WORD &&
				(is_letter(b) || is_digit(b) || b == CH_UNDER)) begin
			if (run_len < PREFIX_LEN)
				prefix = {prefix[39:0], b};
			run_len = bump(run_len);
			col_no  = bump(col_no);
		end else if (scan_state == MODE_NUMBER && (is_digit(b) || b == CH_DOT)) begin
			if (b == CH_DOT)
				dot_seen = 1'b1;
			run_len = bump(run_len);
			col_no  = bump(col_no);
		end else begin
			close_open();
			if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
				if (b == CH_NEWLINE) begin
					line_no = bump(line_no);
					col_no  = 16'd1;
				end else begin
					col_no = bump(col_no);
				end
			end else if (is_letter(b) || b == CH_UNDER) begin
				scan_state = MODE_WORD;
				token_col  = col_no;
				col_no     = bump(col_no);
				run_len    = 16'd1;
				prefix     = {40'd0, b};
			end else if (is_digit(b)) begin
				scan_state = MODE_NUMBER;
				token_col  = col_no;
				col_no     = bump(col_no);
				run_len    = 16'd1;
				dot_seen   = 1'b0;
			end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
				// string column starts after the opening quote
				scan_state  = MODE_STRING;
				dquote_open = (b == CH_DQUOTE);
				col_no      = bump(col_no);
				token_col   = col_no;
				run_len     = 16'd0;
			end else begin
				case (b)
					"(":     ty = TT_LPAREN;
					")":     ty = TT_RPAREN;
					",":     ty = TT_COMMA;
					";":     ty = TT_SEMI;
					default: ty = TT_UNKNOWN;
				endcase
				note_token(ty, col_no, 16'd1, b);
				col_no = bump(col_no);
			end
		end
		// tag the final token of this transaction
		while (step_tokens.size() > 0) begin
			t = step_tokens.pop_front();
			t.last_of_run = (step_tokens.size() == 0);
			expected_tokens = {expected_tokens, t};
		end
	endfunction

	task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
		$display("token %0d: %s is %0d, expected %0d", checked, what, got_v, want_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			lexer_clear();
			step_tokens.delete();
			expected_tokens.delete();
			checked    = 0;
			mismatches = 0;
			pending    = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected token of type", token.token_type, 0);
				end else begin
					want = expected_tokens.pop_front();
					if (token.token_type != want.token_type)
						report_mismatch("type", token.token_type, want.token_type);
					if (token.token_line != want.token_line)
						report_mismatch("line", token.token_line, want.token_line);
					if (token.token_column != want.token_column)
						report_mismatch("column", token.token_column, want.token_column);
					if (token.token_length != want.token_length)
						report_mismatch("length", token.token_length, want.token_length);
					if (token.symbol_byte != want.symbol_byte)
						report_mismatch("symbol", token.symbol_byte, want.symbol_byte);
					if (token.last_of_run != want.last_of_run)
						report_mismatch("last flag", token.last_of_run, want.last_of_run);
				end
				checked++;
			end
			if (push && !full)
				lex_byte(item);
			pending = expected_tokens.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import sqt_pkg::*;

	localparam int   ITEM_TARGET = 1100;
	localparam int   QUIET_LIMIT = 3000;
	localparam int   LONG_HOLD   = 300;
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_END    = 1'b1;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   push;
	logic   full;
	item_t  item;
	logic   empty;
	logic   pop;
	token_t token;
	int     mismatches;
	int     pending;
	int     items_sent = 0;
	int     quiet_cycles = 0;
	int     tx_gap_pct = 0;
	int     rx_gap_pct = 0;
	logic   hold_request = 1'b0;

	always #5 clk = ~clk;

	sql_subset_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

	sqt_token_checker token_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.token      (token),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// watchdog: stop when no transaction moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// token receiver
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				// hold off long enough for the input side to back up
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 99) < rx_gap_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic k, input logic [7:0] b);
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item <= '{kind: k, text_byte: b};
		push <= 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(KIND_DATA, s[i]);
	endtask

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'("A" + r);
		if (r < 52)
			return 8'("a" + r - 26);
		if (r < 62)
			return 8'("0" + r - 52);
		return 8'h5F;
	endfunction

	task automatic send_random_token();
		int         pick;
		int         k;
		int         kw_len;
		int         n;
		int         variant;
		logic [7:0] ch;
		logic [7:0] q;
		pick = $urandom_range(0, 19);
		if (pick < 6) begin
			// keyword, sometimes cut short, lengthened or with a lowercase start
			k       = $urandom_range(0, NUM_KW - 1);
			kw_len  = KW_LEN[k];
			variant = $urandom_range(0, 7);
			n       = (variant == 0) ? $urandom_range(1, kw_len - 1) : kw_len;
			for (int i = 0; i < n; i++) begin
				ch = KW_TEXT[k][8 * (kw_len - 1 - i) +: 8];
				if (variant == 1 && i == 0)
					ch = ch | 8'h20;
				send_item(KIND_DATA, ch);
			end
			if (variant == 2)
				send_item(KIND_DATA, word_char());
		end else if (pick < 9) begin
			do ch = word_char(); while (ch >= "0" && ch <= "9");
			send_item(KIND_DATA, ch);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 19) : $urandom_range(0, 5);
			repeat (n) send_item(KIND_DATA, word_char());
		end else if (pick < 12) begin
			send_item(KIND_DATA, 8'("0" + $urandom_range(0, 9)));
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 3) == 0)
					send_item(KIND_DATA, ".");
				else
					send_item(KIND_DATA, 8'("0" + $urandom_range(0, 9)));
			end
		end else if (pick < 14) begin
			q = $urandom_range(0, 1) ? "\"" : "'";
			send_item(KIND_DATA, q);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 7))
					0:       send_item(KIND_DATA, "\n");
					1:       send_item(KIND_DATA, (q == "'") ? "\"" : "'");
					default: send_item(KIND_DATA, 8'($urandom_range(32, 126)));
				endcase
			end
			// leave some strings open
			if ($urandom_range(0, 7) != 0)
				send_item(KIND_DATA, q);
		end else if (pick < 17) begin
			case ($urandom_range(0, 3))
				0:       send_item(KIND_DATA, "(");
				1:       send_item(KIND_DATA, ")");
				2:       send_item(KIND_DATA, ",");
				default: send_item(KIND_DATA, ";");
			endcase
		end else begin
			send_item(KIND_DATA, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int ntok;
		bit hold_done;
		hold_done = 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tokens back to back, byte extremes, open string at end of input
		send_text("SELECT(a_1,2.5);");
		send_item(KIND_END, 8'hFF);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_DATA, 8'h00);
		send_text("'x\n\"y");
		send_item(KIND_END, 8'h00);

		while (items_sent < ITEM_TARGET) begin
			if (items_sent > 900) begin
				tx_gap_pct = 0;
				rx_gap_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0:       tx_gap_pct = 0;
					1:       tx_gap_pct = 10;
					default: tx_gap_pct = 35;
				endcase
				case ($urandom_range(0, 2))
					0:       rx_gap_pct = 0;
					1:       rx_gap_pct = 10;
					default: rx_gap_pct = 35;
				endcase
			end
			if (!hold_done && items_sent > 300) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			ntok = $urandom_range(1, 12);
			repeat (ntok) begin
				send_random_token();
				case ($urandom_range(0, 13))
					5, 6, 7: send_item(KIND_DATA, " ");
					8:       send_item(KIND_DATA, 8'h09);
					9:       send_item(KIND_DATA, "\n");
					10:      send_item(KIND_DATA, 8'h0D);
					11:      send_item(KIND_DATA, 8'h0B);
					12:      send_item(KIND_DATA, 8'h0C);
					13:      send_text("\n  ");
					default: ;
				endcase
			end
			// now and then let the next text run on without an end mark
			if ($urandom_range(0, 7) != 0)
				send_item(KIND_END, 8'($urandom_range(0, 255)));
		end

		// close the last text with punctuation back to back
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		send_item(KIND_END, 8'h00);
		send_text(");(");
		send_item(KIND_END, 8'h00);
		push <= 1'b0;

		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
design/sqt_pkg.sv
design/sqt_fifo.sv
design/sqt_front.sv
design/sqt_back.sv
design/sql_subset_tokenizer.sv
design/sqt_checker.sv
bench/sqt_token_checker.sv
bench/tb_top.sv
